FILE: hw/rtl/mrsc_pkg.sv
// ----------------------------------------------------------------------------
// mrsc_pkg
// shared types and constants of the two-layer perceptron classifier
// ----------------------------------------------------------------------------
package mrsc_pkg;

  localparam int DEF_MAX_FEATURES = 32;
  localparam int DEF_MAX_HIDDEN   = 32;
  localparam int DEF_MAX_CLASSES  = 4;

  // request codes on func
  localparam logic [2:0] FUNC_HIDDEN_WEIGHT = 3'd0;
  localparam logic [2:0] FUNC_HIDDEN_BIAS   = 3'd1;
  localparam logic [2:0] FUNC_OUTPUT_WEIGHT = 3'd2;
  localparam logic [2:0] FUNC_OUTPUT_BIAS   = 3'd3;
  localparam logic [2:0] FUNC_FEATURE       = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_FEATURES_USED = 2'd0;
  localparam logic [1:0] REG_HIDDEN_USED   = 2'd1;
  localparam logic [1:0] REG_CLASSES_USED  = 2'd2;

  localparam int ACC_W   = 48;
  localparam int LOGIT_W = 40;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int EX_W    = 17;
  localparam int SUM_W   = 21;
  localparam int DIV_DW  = 33;
  localparam int DIV_VW  = SUM_W;

  localparam logic [MUL_W-1:0] LOG2E_Q30 = 33'd1549082005;
  localparam logic [MUL_W-1:0] LN2_Q30   = 33'd744261118;
  localparam logic [30:0]      ONE_Q30   = 31'h4000_0000;
  localparam logic [LOGIT_W:0] EXP_LIMIT = 41'h000_1000_0000;
  localparam logic [3:0]       TAYLOR_TERMS = 4'd12;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HB_RD, S_HB_LD, S_H_RD, S_H_MUL, S_H_ACC, S_H_WR,
    S_O_LD, S_O_RD, S_O_MUL, S_O_ACC, S_O_WR, S_MAX,
    S_X_T, S_X_U, S_X_F, S_X_Y, S_X_M, S_X_D, S_X_W, S_X_E,
    S_P_D, S_P_W, S_OUT
  } state_t;

endpackage

FILE: hw/rtl/mrsc_ram.sv
// ----------------------------------------------------------------------------
// mrsc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mrsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mrsc_div.sv
// ----------------------------------------------------------------------------
// mrsc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mrsc_div (
  input  logic               clk,
  input  logic               rst,
  input  mrsc_pkg::div_req_t req,
  output mrsc_pkg::div_rsp_t rsp
);
  import mrsc_pkg::*;

  localparam int CW = $clog2(DIV_DW);

  logic              busy;
  logic              done;
  logic [CW-1:0]     cnt;
  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dv;
  logic [DIV_DW-1:0] quo;
  logic [DIV_VW:0]   trial;
  logic              ge;

  assign trial = {rem, quo[DIV_DW-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DIV_DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      dv  <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= ge ? DIV_VW'(trial - {1'b0, dv}) : trial[DIV_VW-1:0];
      quo <= {quo[DIV_DW-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hw/rtl/mlp_relu_softmax_classifier.sv
// ----------------------------------------------------------------------------
// mlp_relu_softmax_classifier
// two-layer perceptron with relu hidden layer and softmax output
// ----------------------------------------------------------------------------
// Load requests (weights, biases, features) are accepted while the block is
// idle. The feature request with index features_used-1 starts an inference,
// during which the block is not ready: every product goes through one shared
// 33x33 multiplier; softmax then computes exp per class with twelve Taylor
// terms, each a multiply and a division in the one serial divider, and one
// more division per class for the probability. The C results then leave one
// per accepted cycle.
module mlp_relu_softmax_classifier #(
  parameter int MAX_FEATURES = mrsc_pkg::DEF_MAX_FEATURES,
  parameter int MAX_HIDDEN   = mrsc_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_CLASSES  = mrsc_pkg::DEF_MAX_CLASSES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [4:0]  row,
  input  logic [4:0]  col,
  input  logic signed [15:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  class_index,
  output logic [15:0] probability,
  output logic [2:0]  predicted_label,
  output logic        last
);
  import mrsc_pkg::*;

  localparam int FA_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int HA_W  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int CA_W  = $clog2(MAX_CLASSES);
  localparam int HWD   = MAX_HIDDEN * MAX_FEATURES;
  localparam int HW_AW = (HWD > 1) ? $clog2(HWD) : 1;
  localparam int OWD   = MAX_CLASSES * MAX_HIDDEN;
  localparam int OW_AW = $clog2(OWD);

  state_t state, state_next;

  logic [5:0] features_used, hidden_used;
  logic [2:0] classes_used;
  logic [FA_W-1:0] fu_last;
  logic [HA_W-1:0] hu_last;
  logic [CA_W-1:0] cu_last;

  logic [FA_W-1:0] f_idx;
  logic [HA_W-1:0] h_idx;
  logic [CA_W-1:0] c_idx;

  logic accept;
  logic hw_we, hb_we, ow_we, ob_we, ft_we, trigger;
  logic [15:0] hw_q, hb_q, ow_q, ft_q, act_q, act_wdata;
  logic act_we;

  logic signed [15:0] ob [MAX_CLASSES];
  logic [LOGIT_W-1:0] logit [MAX_CLASSES];
  logic [EX_W-1:0]    ex [MAX_CLASSES];
  logic [15:0]        pr [MAX_CLASSES];

  logic [ACC_W-1:0]   acc;
  logic [LOGIT_W-1:0] logit_sat;
  logic [LOGIT_W-1:0] mx;
  logic [LOGIT_W:0]   t_diff, t_reg;
  logic               t_big;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [4:0]  n_reg;
  logic [29:0] y_reg;
  logic [30:0] term;
  logic signed [33:0] e_acc;
  logic [30:0] e_clamp;
  logic [37:0] e_round;
  logic [EX_W-1:0] ex_val;
  logic [3:0]  t_idx;
  logic [SUM_W-1:0] sum;
  logic [CA_W-1:0] best;
  logic [15:0] best_pr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // clamp the registers to their usable range
  always_comb begin
    if (features_used == 6'd0) begin
      fu_last = '0;
    end else if (32'(features_used) > MAX_FEATURES) begin
      fu_last = FA_W'(MAX_FEATURES - 1);
    end else begin
      fu_last = FA_W'(32'(features_used) - 32'd1);
    end
    if (hidden_used == 6'd0) begin
      hu_last = '0;
    end else if (32'(hidden_used) > MAX_HIDDEN) begin
      hu_last = HA_W'(MAX_HIDDEN - 1);
    end else begin
      hu_last = HA_W'(32'(hidden_used) - 32'd1);
    end
    if (classes_used < 3'd2) begin
      cu_last = CA_W'(1);
    end else if (32'(classes_used) > MAX_CLASSES) begin
      cu_last = CA_W'(MAX_CLASSES - 1);
    end else begin
      cu_last = CA_W'(32'(classes_used) - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      features_used <= 6'd32;
      hidden_used   <= 6'd32;
      classes_used  <= 3'd3;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FEATURES_USED: features_used <= cfg_data;
        REG_HIDDEN_USED:   hidden_used   <= cfg_data;
        REG_CLASSES_USED:  classes_used  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign hw_we = accept && func == FUNC_HIDDEN_WEIGHT && 32'(row) < MAX_HIDDEN
                 && 32'(col) < MAX_FEATURES;
  assign hb_we = accept && func == FUNC_HIDDEN_BIAS && 32'(row) < MAX_HIDDEN;
  assign ow_we = accept && func == FUNC_OUTPUT_WEIGHT && 32'(row) < MAX_CLASSES
                 && 32'(col) < MAX_HIDDEN;
  assign ob_we = accept && func == FUNC_OUTPUT_BIAS && 32'(row) < MAX_CLASSES;
  assign ft_we = accept && func == FUNC_FEATURE && 32'(col) < MAX_FEATURES;
  assign trigger = ft_we && 32'(col) == 32'(fu_last);

  mrsc_ram #(.WIDTH(16), .DEPTH(HWD)) u_hw_ram (
    .clk(clk), .we(hw_we),
    .waddr(HW_AW'(32'(row) * MAX_FEATURES + 32'(col))), .wdata(value),
    .raddr(HW_AW'(32'(h_idx) * MAX_FEATURES + 32'(f_idx))), .rdata(hw_q)
  );

  mrsc_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN)) u_hb_ram (
    .clk(clk), .we(hb_we), .waddr(HA_W'(32'(row))), .wdata(value),
    .raddr(h_idx), .rdata(hb_q)
  );

  mrsc_ram #(.WIDTH(16), .DEPTH(OWD)) u_ow_ram (
    .clk(clk), .we(ow_we),
    .waddr(OW_AW'(32'(row) * MAX_HIDDEN + 32'(col))), .wdata(value),
    .raddr(OW_AW'(32'(c_idx) * MAX_HIDDEN + 32'(h_idx))), .rdata(ow_q)
  );

  mrsc_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_ft_ram (
    .clk(clk), .we(ft_we), .waddr(FA_W'(32'(col))), .wdata(value),
    .raddr(f_idx), .rdata(ft_q)
  );

  mrsc_ram #(.WIDTH(16), .DEPTH(MAX_HIDDEN)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(h_idx), .wdata(act_wdata),
    .raddr(h_idx), .rdata(act_q)
  );

  mrsc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (ob_we) begin
      ob[CA_W'(32'(row))] <= value;
    end
  end

  // relu, drop the low 12 fraction bits, saturate to q4.12
  always_comb begin
    if (acc[ACC_W-1] || acc == '0) begin
      act_wdata = '0;
    end else if (|acc[ACC_W-2:27]) begin
      act_wdata = 16'h7fff;
    end else begin
      act_wdata = acc[27:12];
    end
  end

  always_comb begin
    if (!acc[ACC_W-1] && |acc[ACC_W-2:LOGIT_W-1]) begin
      logit_sat = {1'b0, {(LOGIT_W-1){1'b1}}};
    end else if (acc[ACC_W-1] && !(&acc[ACC_W-2:LOGIT_W-1])) begin
      logit_sat = {1'b1, {(LOGIT_W-1){1'b0}}};
    end else begin
      logit_sat = acc[LOGIT_W-1:0];
    end
  end

  assign t_diff = {mx[LOGIT_W-1], mx} - {logit[c_idx][LOGIT_W-1], logit[c_idx]};
  assign t_big  = t_diff > EXP_LIMIT;

  always_comb begin
    if (e_acc < 0) begin
      e_clamp = '0;
    end else if (e_acc > 34'(ONE_Q30)) begin
      e_clamp = ONE_Q30;
    end else begin
      e_clamp = e_acc[30:0];
    end
    e_round = 38'(e_clamp) + (38'd1 << (6'(n_reg) + 6'd13));
    ex_val  = EX_W'(e_round >> (6'(n_reg) + 6'd14));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    act_we = 1'b0;
    out_valid = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    case (state)
      S_IDLE: if (trigger) state_next = S_HB_RD;
      S_HB_RD: state_next = S_HB_LD;
      S_HB_LD: state_next = S_H_RD;
      S_H_RD: state_next = S_H_MUL;
      S_H_MUL: begin
        mul_a = MUL_W'(signed'(hw_q));
        mul_b = MUL_W'(signed'(ft_q));
        state_next = S_H_ACC;
      end
      S_H_ACC: state_next = (f_idx == fu_last) ? S_H_WR : S_H_RD;
      S_H_WR: begin
        act_we = 1'b1;
        state_next = (h_idx == hu_last) ? S_O_LD : S_HB_RD;
      end
      S_O_LD: state_next = S_O_RD;
      S_O_RD: state_next = S_O_MUL;
      S_O_MUL: begin
        mul_a = MUL_W'(signed'(ow_q));
        mul_b = MUL_W'(signed'(act_q));
        state_next = S_O_ACC;
      end
      S_O_ACC: state_next = (h_idx == hu_last) ? S_O_WR : S_O_RD;
      S_O_WR: state_next = (c_idx == cu_last) ? S_MAX : S_O_LD;
      S_MAX: if (c_idx == cu_last) state_next = S_X_T;
      S_X_T: begin
        if (!t_big) begin
          state_next = S_X_U;
        end else if (c_idx == cu_last) begin
          state_next = S_P_D;
        end
      end
      S_X_U: begin
        mul_a = MUL_W'(t_reg[28:0]);
        mul_b = LOG2E_Q30;
        state_next = S_X_F;
      end
      S_X_F: begin
        mul_a = MUL_W'(prod[53:30]);
        mul_b = LN2_Q30;
        state_next = S_X_Y;
      end
      S_X_Y: state_next = S_X_M;
      S_X_M: begin
        mul_a = MUL_W'(term);
        mul_b = MUL_W'(y_reg);
        state_next = S_X_D;
      end
      S_X_D: begin
        div_req.start = 1'b1;
        div_req.dividend = DIV_DW'(prod[60:30]);
        div_req.divisor = DIV_VW'(t_idx);
        state_next = S_X_W;
      end
      S_X_W: begin
        if (div_rsp.done) begin
          state_next = (t_idx == TAYLOR_TERMS) ? S_X_E : S_X_M;
        end
      end
      S_X_E: state_next = (c_idx == cu_last) ? S_P_D : S_X_T;
      S_P_D: begin
        div_req.start = 1'b1;
        div_req.dividend = DIV_DW'({ex[c_idx], 16'b0}) - DIV_DW'(ex[c_idx]);
        div_req.divisor = sum;
        state_next = S_P_W;
      end
      S_P_W: begin
        if (div_rsp.done) begin
          state_next = (c_idx == cu_last) ? S_OUT : S_P_D;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready && c_idx == cu_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: h_idx <= '0;
      S_HB_LD: begin
        acc <= {{(ACC_W-28){hb_q[15]}}, hb_q, 12'b0};
        f_idx <= '0;
      end
      S_H_ACC: begin
        acc <= acc + prod[ACC_W-1:0];
        if (f_idx != fu_last) f_idx <= f_idx + 1'b1;
      end
      S_H_WR: begin
        if (h_idx == hu_last) begin
          c_idx <= '0;
        end else begin
          h_idx <= h_idx + 1'b1;
        end
      end
      S_O_LD: begin
        acc <= {{(ACC_W-28){ob[c_idx][15]}}, ob[c_idx], 12'b0};
        h_idx <= '0;
      end
      S_O_ACC: begin
        acc <= acc + prod[ACC_W-1:0];
        if (h_idx != hu_last) h_idx <= h_idx + 1'b1;
      end
      S_O_WR: begin
        logit[c_idx] <= logit_sat;
        c_idx <= (c_idx == cu_last) ? '0 : c_idx + 1'b1;
      end
      S_MAX: begin
        sum <= '0;
        if (c_idx == '0 || $signed(logit[c_idx]) > $signed(mx)) mx <= logit[c_idx];
        c_idx <= (c_idx == cu_last) ? '0 : c_idx + 1'b1;
      end
      S_X_T: begin
        t_reg <= t_diff;
        if (t_big) begin
          ex[c_idx] <= '0;
          c_idx <= (c_idx == cu_last) ? '0 : c_idx + 1'b1;
        end
      end
      S_X_F: n_reg <= prod[58:54];
      S_X_Y: begin
        y_reg <= prod[53:24];
        term  <= ONE_Q30;
        e_acc <= 34'(ONE_Q30);
        t_idx <= 4'd1;
      end
      S_X_W: begin
        if (div_rsp.done) begin
          term <= div_rsp.quotient[30:0];
          // odd terms of the series subtract
          if (t_idx[0]) begin
            e_acc <= e_acc - 34'(div_rsp.quotient[30:0]);
          end else begin
            e_acc <= e_acc + 34'(div_rsp.quotient[30:0]);
          end
          t_idx <= t_idx + 1'b1;
        end
      end
      S_X_E: begin
        ex[c_idx] <= ex_val;
        sum <= sum + SUM_W'(ex_val);
        c_idx <= (c_idx == cu_last) ? '0 : c_idx + 1'b1;
      end
      S_P_W: begin
        if (div_rsp.done) begin
          pr[c_idx] <= div_rsp.quotient[15:0];
          // first maximum wins ties
          if (c_idx == '0 || div_rsp.quotient[15:0] > best_pr) begin
            best    <= c_idx;
            best_pr <= div_rsp.quotient[15:0];
          end
          c_idx <= (c_idx == cu_last) ? '0 : c_idx + 1'b1;
        end
      end
      S_OUT: if (out_ready) c_idx <= c_idx + 1'b1;
      default: ;
    endcase
  end

  assign class_index     = 2'(32'(c_idx));
  assign probability     = pr[c_idx];
  assign predicted_label = 3'(32'(best) + 32'd1);
  assign last            = (c_idx == cu_last);

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// two-layer perceptron classifier: a directed table of load and feature
// requests, then random samples under several sizes, each result checked
// against an in-bench fixed-point prediction of relu, logits and softmax
// ----------------------------------------------------------------------------
module tb;
  import mrsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = DEF_MAX_FEATURES;
  localparam int NH = DEF_MAX_HIDDEN;
  localparam int NC = DEF_MAX_CLASSES;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam longint unsigned LOG2E_FX = 64'd1549082005;
  localparam longint unsigned LN2_FX   = 64'd744261118;
  localparam longint LOGIT_HI = (64'sd1 <<< 39) - 1;
  localparam longint LOGIT_LO = -(64'sd1 <<< 39);

  typedef struct {
    logic [1:0]  cls;
    logic [15:0] prob;
    logic [2:0]  label;
    logic        last;
  } class_result_t;

  typedef struct {
    logic [2:0]  f;
    logic [4:0]  r;
    logic [4:0]  c;
    logic [15:0] v;
    bit          typed;
    logic [15:0] tprob;
    logic [2:0]  tlabel;
  } req_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [2:0] func;
  logic [4:0] row;
  logic [4:0] col;
  logic signed [15:0] value;
  logic out_valid;
  logic out_ready;
  logic [1:0] class_index;
  logic [15:0] probability;
  logic [2:0] predicted_label;
  logic last;

  mlp_relu_softmax_classifier uut (.*);

  always #2 clk = ~clk;

  // mirror of the block state
  logic signed [15:0] hw_mem [NH*NF];
  logic signed [15:0] hb_mem [NH];
  logic signed [15:0] ow_mem [NC*NH];
  logic signed [15:0] ob_mem [NC];
  logic signed [15:0] feat_mem [NF];
  bit hw_ok [NH*NF];
  bit hb_ok [NH];
  bit ow_ok [NC*NH];
  bit ob_ok [NC];
  bit feat_ok [NF];
  logic [5:0] features_reg, hidden_reg;
  logic [2:0] classes_reg;

  class_result_t pending_results[$];
  class_result_t new_results [NC];
  int errors;
  longint cycles;
  bit gaps_on;
  int rx_hold;

  function automatic int used_features();
    return features_reg < 1 ? 1 : (features_reg > NF ? NF : features_reg);
  endfunction

  function automatic int used_hidden();
    return hidden_reg < 1 ? 1 : (hidden_reg > NH ? NH : hidden_reg);
  endfunction

  function automatic int used_classes();
    return classes_reg < 2 ? 2 : (classes_reg > NC ? NC : classes_reg);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    if (r < 7) return 16'($signed($urandom_range(0, 2048)) - 1024);
    return 16'($urandom);
  endfunction

  // exp(-t) for t in Q.24, result Q0.16 with 1.0 = 65536
  function automatic longint unsigned exp_neg_q16(longint unsigned t);
    longint unsigned u, n, fr, y, term;
    longint acc;
    if (t > (64'd16 << 24)) return 0;
    u = (t * LOG2E_FX) >> 30;
    n = u >> 24;
    fr = u & 64'hff_ffff;
    y = (fr * LN2_FX) >> 24;
    acc = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * y) >> 30) / longint'(i);
      if (i % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return (longint'(acc) + (64'd1 << (13 + n))) >> (14 + n);
  endfunction

  // full forward pass; fills new_results and returns the class count
  function automatic int classify();
    int fu, hu, cu, best;
    longint acc, mx;
    longint hact [NH];
    longint logit [NC];
    longint unsigned ex [NC];
    longint unsigned pr [NC];
    longint unsigned total;
    fu = used_features();
    hu = used_hidden();
    cu = used_classes();
    for (int i = 0; i < hu; i++) begin
      acc = longint'(hb_mem[i]) * 4096;
      for (int j = 0; j < fu; j++)
        acc += longint'(hw_mem[i*NF+j]) * longint'(feat_mem[j]);
      if (acc < 0) acc = 0;
      acc = acc / 4096;
      hact[i] = acc > 32767 ? 32767 : acc;
    end
    for (int k = 0; k < cu; k++) begin
      acc = longint'(ob_mem[k]) * 4096;
      for (int j = 0; j < hu; j++)
        acc += longint'(ow_mem[k*NH+j]) * hact[j];
      if (acc > LOGIT_HI) acc = LOGIT_HI;
      if (acc < LOGIT_LO) acc = LOGIT_LO;
      logit[k] = acc;
    end
    mx = logit[0];
    for (int k = 1; k < cu; k++) if (logit[k] > mx) mx = logit[k];
    total = 0;
    for (int k = 0; k < cu; k++) begin
      ex[k] = exp_neg_q16(longint'(mx - logit[k]));
      total += ex[k];
    end
    best = 0;
    for (int k = 0; k < cu; k++) begin
      pr[k] = (ex[k] * 65535) / total;
      if (pr[k] > pr[best]) best = k;
    end
    for (int k = 0; k < cu; k++) begin
      new_results[k].cls = 2'(k);
      new_results[k].prob = 16'(pr[k]);
      new_results[k].label = 3'(best + 1);
      new_results[k].last = (k == cu - 1);
    end
    return cu;
  endfunction

  // update the mirror for one accepted request, return results caused
  function automatic int apply_request(logic [2:0] f, logic [4:0] r, logic [4:0] c,
                                       logic [15:0] v);
    case (f)
      FUNC_HIDDEN_WEIGHT: begin
        hw_mem[r*NF+c] = v;
        hw_ok[r*NF+c] = 1;
      end
      FUNC_HIDDEN_BIAS: begin
        hb_mem[r] = v;
        hb_ok[r] = 1;
      end
      FUNC_OUTPUT_WEIGHT: if (r < NC) begin
        ow_mem[r*NH+c] = v;
        ow_ok[r*NH+c] = 1;
      end
      FUNC_OUTPUT_BIAS: if (r < NC) begin
        ob_mem[r] = v;
        ob_ok[r] = 1;
      end
      FUNC_FEATURE: begin
        feat_mem[c] = v;
        feat_ok[c] = 1;
        if (c == used_features() - 1) return classify();
      end
      default: ;
    endcase
    return 0;
  endfunction

  // entered just after a rising edge; leaves valid high after the accept
  task automatic drive_req(logic [2:0] f, logic [4:0] r, logic [4:0] c, logic [15:0] v,
                           bit typed = 0, logic [15:0] tprob = 0, logic [2:0] tlabel = 0);
    int gap, n;
    class_result_t t;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    row <= r;
    col <= c;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = apply_request(f, r, c, v);
    for (int k = 0; k < n; k++) begin
      t = new_results[k];
      if (typed) begin
        t.prob = tprob;
        t.label = tlabel;
      end
      pending_results.push_back(t);
    end
  endtask

  // before a request that starts an inference, write every entry it reads that is not yet loaded, then send the request
  task automatic send_req(logic [2:0] f, logic [4:0] r, logic [4:0] c, logic [15:0] v);
    int fu, hu, cu;
    fu = used_features();
    hu = used_hidden();
    cu = used_classes();
    if (f == FUNC_FEATURE && c == fu - 1) begin
      for (int i = 0; i < hu; i++) begin
        for (int j = 0; j < fu; j++)
          if (!hw_ok[i*NF+j]) drive_req(FUNC_HIDDEN_WEIGHT, 5'(i), 5'(j), rand_value());
        if (!hb_ok[i]) drive_req(FUNC_HIDDEN_BIAS, 5'(i), 5'(0), rand_value());
      end
      for (int k = 0; k < cu; k++) begin
        for (int j = 0; j < hu; j++)
          if (!ow_ok[k*NH+j]) drive_req(FUNC_OUTPUT_WEIGHT, 5'(k), 5'(j), rand_value());
        if (!ob_ok[k]) drive_req(FUNC_OUTPUT_BIAS, 5'(k), 5'(0), rand_value());
      end
      for (int j = 0; j < fu - 1; j++)
        if (!feat_ok[j]) drive_req(FUNC_FEATURE, 5'(0), 5'(j), rand_value());
    end
    drive_req(f, r, c, v);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_FEATURES_USED: features_reg = data;
      REG_HIDDEN_USED:   hidden_reg = data;
      REG_CLASSES_USED:  classes_reg = data[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_sample();
    int extra, fu, k;
    fu = used_features();
    extra = $urandom_range(0, 7);
    for (int i = 0; i < extra; i++) begin
      k = $urandom_range(0, 9);
      if (k < 5)
        send_req(3'($urandom_range(0, 3)), 5'($urandom), 5'($urandom), rand_value());
      else if (k < 6)
        send_req(3'($urandom_range(5, 7)), 5'($urandom), 5'($urandom), 16'($urandom));
      else
        send_req(FUNC_FEATURE, 5'($urandom), 5'($urandom_range(0, 31)), rand_value());
    end
    send_req(FUNC_FEATURE, 5'($urandom), 5'(fu - 1), rand_value());
  endtask

  // sizes per phase, including out-of-range writes that saturate
  int ph_f [8] = '{1, 4, 0, 32, 7, 63, 5, 32};
  int ph_h [8] = '{1, 3, 40, 2, 5, 0, 8, 2};
  int ph_c [8] = '{2, 4, 1, 4, 61, 0, 3, 3};
  int ph_n [8] = '{8, 8, 4, 2, 8, 3, 8, 2};

  req_row_t dir_rows [23] = '{
    '{FUNC_HIDDEN_WEIGHT, 5'd0,  5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_HIDDEN_WEIGHT, 5'd0,  5'd1,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_HIDDEN_BIAS,   5'd0,  5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_WEIGHT, 5'd0,  5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_WEIGHT, 5'd1,  5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_BIAS,   5'd0,  5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_BIAS,   5'd1,  5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_FEATURE,       5'd0,  5'd0,  16'h7fff, 0, 16'd0, 3'd0},
    // all-zero network: both classes share the probability evenly
    '{FUNC_FEATURE,       5'd0,  5'd1,  16'h8000, 1, 16'd32767, 3'd1},
    '{3'd5,               5'd31, 5'd31, 16'hffff, 0, 16'd0, 3'd0},
    '{3'd6,               5'd0,  5'd0,  16'h1234, 0, 16'd0, 3'd0},
    '{3'd7,               5'd31, 5'd0,  16'h0000, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_WEIGHT, 5'd31, 5'd31, 16'h7fff, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_BIAS,   5'd7,  5'd0,  16'h8000, 0, 16'd0, 3'd0},
    '{FUNC_HIDDEN_WEIGHT, 5'd31, 5'd31, 16'h7fff, 0, 16'd0, 3'd0},
    '{FUNC_HIDDEN_WEIGHT, 5'd0,  5'd0,  16'h7fff, 0, 16'd0, 3'd0},
    '{FUNC_HIDDEN_WEIGHT, 5'd0,  5'd1,  16'h8000, 0, 16'd0, 3'd0},
    '{FUNC_HIDDEN_BIAS,   5'd0,  5'd0,  16'h7fff, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_WEIGHT, 5'd1,  5'd0,  16'h7fff, 0, 16'd0, 3'd0},
    '{FUNC_OUTPUT_BIAS,   5'd0,  5'd0,  16'h8000, 0, 16'd0, 3'd0},
    '{FUNC_FEATURE,       5'd0,  5'd5,  16'h8000, 0, 16'd0, 3'd0},
    '{FUNC_FEATURE,       5'd0,  5'd0,  16'h8000, 0, 16'd0, 3'd0},
    '{FUNC_FEATURE,       5'd31, 5'd1,  16'h7fff, 0, 16'd0, 3'd0}
  };

  // receiver stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) < 3) rx_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    class_result_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result class %0d prob %0d", class_index,
                                  probability);
      end else begin
        e = pending_results.pop_front();
        if (class_index !== e.cls || probability !== e.prob ||
            predicted_label !== e.label || last !== e.last) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch exp cls %0d prob %0d label %0d last %0d, got %0d %0d %0d %0d",
                     e.cls, e.prob, e.label, e.last, class_index, probability,
                     predicted_label, last);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = REG_FEATURES_USED;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_HIDDEN_WEIGHT;
    row = '0;
    col = '0;
    value = '0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    rx_hold = 0;
    gaps_on = 1;
    features_reg = 6'd32;
    hidden_reg = 6'd32;
    classes_reg = 3'd3;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_FEATURES_USED, 6'd2);
    write_reg(REG_HIDDEN_USED, 6'd1);
    write_reg(REG_CLASSES_USED, 6'd2);
    foreach (dir_rows[i])
      drive_req(dir_rows[i].f, dir_rows[i].r, dir_rows[i].c, dir_rows[i].v,
                dir_rows[i].typed, dir_rows[i].tprob, dir_rows[i].tlabel);
    drain();

    for (int p = 0; p < 8; p++) begin
      gaps_on = (p % 3 != 2);
      write_reg(REG_FEATURES_USED, 6'(ph_f[p]));
      write_reg(REG_HIDDEN_USED, 6'(ph_h[p]));
      write_reg(REG_CLASSES_USED, 6'(ph_c[p]));
      if (p == 4) write_reg(REG_SPARE, 6'h3f);
      for (int s = 0; s < ph_n[p]; s++) random_sample();
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mrsc_pkg.sv
hw/rtl/mrsc_ram.sv
hw/rtl/mrsc_div.sv
hw/rtl/mlp_relu_softmax_classifier.sv
verif/tb.sv
